// ----- rtl/pwlti_pkg.sv -----
// Shared constants for the piecewise-linear table interpolator.
// No dependencies; used by piecewise_linear_table_interpolator.
package pwlti_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int X_W     = 32;
    localparam int Y_W     = 48;
    localparam int IDX_W   = 8;
    localparam int PIU_W   = 9;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 48;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word indexes.
    localparam logic REG_POINTS_IN_USE = 1'b0;

    // Request kinds carried on s_tuser.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Arithmetic widths.
    localparam int DY_W   = Y_W + 1;      // ordinate difference magnitude
    localparam int DX_W   = X_W + 1;      // abscissa difference magnitude
    localparam int MLO_W  = 25;           // low slice of the ordinate magnitude
    localparam int MHI_W  = DY_W - MLO_W; // high slice
    localparam int PROD_W = DY_W + DX_W;  // full product width
    localparam int QUO_W  = Y_W + 1;      // quotient bits kept before saturation
    localparam int SUM_W  = Y_W + 3;

    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

endpackage

// ----- rtl/piecewise_linear_table_interpolator.sv -----
// Piecewise-linear interpolator over a table of (x, y) breakpoints.
// Uses pwlti_pkg for widths, register indexes and request kinds.
//
//   Channel   Direction  Carries
//   s_axis    in         breakpoint write or query request
//   m_axis    out        interpolated value and clamp flag, one per query
//   apb       in/out     points_in_use register
//
// A write request is taken while the block is idle. A query reads the breakpoints in
// order, a fetch and a compare state per point, up to n points in use, then set-up,
// the two-slice multiply, the 49-step division, the final add and the output load.
// Reset is synchronous and active low; it clears the register and control state,
// not the breakpoint memories. A result waits in the output register while the next
// request runs; only a finished query whose result cannot be handed over stalls.
module piecewise_linear_table_interpolator #(
    parameter int TABLE_DEPTH = pwlti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: point_index[7:0], point_x[39:8], point_y[87:40], query_x[119:88]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pwlti_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: mode[0]
    input  logic                                s_tuser,
    // m_tdata: value[47:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pwlti_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: clamped[0]
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pwlti_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pwlti_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pwlti_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = (CW > pwlti_pkg::PIU_W) ? CW : pwlti_pkg::PIU_W;
    localparam int DCW = $clog2(pwlti_pkg::QUO_W);

    localparam int X_W    = pwlti_pkg::X_W;
    localparam int Y_W    = pwlti_pkg::Y_W;
    localparam int DY_W   = pwlti_pkg::DY_W;
    localparam int DX_W   = pwlti_pkg::DX_W;
    localparam int MLO_W  = pwlti_pkg::MLO_W;
    localparam int PROD_W = pwlti_pkg::PROD_W;
    localparam int QUO_W  = pwlti_pkg::QUO_W;
    localparam int SUM_W  = pwlti_pkg::SUM_W;
    localparam int MUL_W  = MLO_W + DX_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_SETUP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_PRECHK,
        ST_DIV,
        ST_FINAL,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [pwlti_pkg::PIU_W-1:0] piu_reg;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               k_reg;
    logic [AW-1:0]               rd_addr_reg;

    logic [X_W-1:0] x_mem [TABLE_DEPTH];
    logic [Y_W-1:0] y_mem [TABLE_DEPTH];
    logic signed [X_W-1:0] x_rd_reg;
    logic signed [Y_W-1:0] y_rd_reg;

    logic signed [X_W-1:0] q_reg;
    logic signed [X_W-1:0] x0_reg, x1_reg;
    logic signed [Y_W-1:0] y0_reg, y1_reg;

    logic [DY_W-1:0]   my_reg;
    logic [DX_W-1:0]   mq_reg;
    logic [DX_W-1:0]   md_reg;
    logic              neg_reg;
    logic [MUL_W-1:0]  plo_reg;
    logic [MUL_W-2:0]  phi_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DX_W-1:0]   rem_reg;
    logic [QUO_W-1:0]  nq_reg;
    logic [DCW-1:0]    cnt_reg;

    logic [Y_W-1:0] res_value_reg;
    logic           res_clamp_reg;
    logic           m_tvalid_reg;
    logic [Y_W-1:0] m_value_reg;
    logic           m_clamp_reg;

    // Request fields.
    logic [pwlti_pkg::IDX_W-1:0] in_index;
    logic [X_W-1:0]              in_x;
    logic [Y_W-1:0]              in_y;
    logic signed [X_W-1:0]       in_q;

    assign in_index = s_tdata[7:0];
    assign in_x     = s_tdata[39:8];
    assign in_y     = s_tdata[87:40];
    assign in_q     = s_tdata[119:88];

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    logic [NW-1:0] wr_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    assign wr_idx  = NW'(in_index);
    assign wr_addr = wr_idx[AW-1:0];
    assign wr_en   = s_acc && (s_tuser == pwlti_pkg::MODE_WRITE)
                     && (wr_idx < NW'(TABLE_DEPTH));

    logic [NW-1:0] piu_ext;
    logic [NW-1:0] n_eff;
    assign piu_ext = NW'(piu_reg);
    assign n_eff   = (piu_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : piu_ext;

    // Configuration port.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == pwlti_pkg::REG_POINTS_IN_USE);
    assign prdata = (paddr[2] == pwlti_pkg::REG_POINTS_IN_USE)
                    ? pwlti_pkg::APB_DATA_W'(piu_reg) : '0;

    // Segment set-up arithmetic.
    logic signed [DY_W-1:0] dy;
    logic signed [DX_W-1:0] dq, dx;
    assign dy = {y1_reg[Y_W-1], y1_reg} - {y0_reg[Y_W-1], y0_reg};
    assign dq = {q_reg[X_W-1], q_reg} - {x0_reg[X_W-1], x0_reg};
    assign dx = {x1_reg[X_W-1], x1_reg} - {x0_reg[X_W-1], x0_reg};

    // Shared multiplier over the two slices of the ordinate magnitude.
    logic [MLO_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_p;
    assign mul_a = (state_reg == ST_MUL_LO) ? my_reg[MLO_W-1:0]
                                            : MLO_W'(my_reg[DY_W-1:MLO_W]);
    assign mul_p = {{DX_W{1'b0}}, mul_a} * {{MLO_W{1'b0}}, mq_reg};

    // Restoring division step.
    logic [DX_W:0] rem_sh, rem_sub;
    logic          div_ge;
    assign rem_sh  = {rem_reg, nq_reg[QUO_W-1]};
    assign rem_sub = rem_sh - {1'b0, md_reg};
    assign div_ge  = (rem_sh >= {1'b0, md_reg});

    // Final add and saturation.
    logic signed [SUM_W-1:0] y0_ext, quo_ext, sum_s;
    assign y0_ext  = SUM_W'(y0_reg);
    assign quo_ext = {2'b00, nq_reg};
    assign sum_s   = neg_reg ? (y0_ext - quo_ext) : (y0_ext + quo_ext);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= in_x;
            y_mem[wr_addr] <= in_y;
        end
        x_rd_reg <= x_mem[rd_addr_reg];
        y_rd_reg <= y_mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            piu_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                piu_reg <= pwdata[pwlti_pkg::PIU_W-1:0];
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && (s_tuser == pwlti_pkg::MODE_QUERY)) begin
                        q_reg <= in_q;
                        n_reg <= n_eff;
                        if (n_eff < NW'(2)) begin
                            res_value_reg <= '0;
                            res_clamp_reg <= 1'b0;
                            state_reg     <= ST_DONE;
                        end else begin
                            k_reg       <= '0;
                            rd_addr_reg <= '0;
                            state_reg   <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (k_reg == '0) begin
                        x0_reg      <= x_rd_reg;
                        y0_reg      <= y_rd_reg;
                        k_reg       <= NW'(1);
                        rd_addr_reg <= AW'(1);
                        state_reg   <= ST_FETCH;
                    end else if (x_rd_reg >= q_reg) begin
                        x1_reg    <= x_rd_reg;
                        y1_reg    <= y_rd_reg;
                        state_reg <= ST_SETUP;
                    end else if (k_reg == n_reg - NW'(1)) begin
                        res_value_reg <= y_rd_reg;
                        res_clamp_reg <= 1'b0;
                        state_reg     <= ST_DONE;
                    end else begin
                        x0_reg      <= x_rd_reg;
                        y0_reg      <= y_rd_reg;
                        k_reg       <= k_reg + NW'(1);
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                        state_reg   <= ST_FETCH;
                    end
                end
                ST_SETUP: begin
                    if (x1_reg == x0_reg) begin
                        res_value_reg <= y1_reg;
                        res_clamp_reg <= 1'b1;
                        state_reg     <= ST_DONE;
                    end else begin
                        my_reg    <= dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
                        mq_reg    <= dq[DX_W-1] ? DX_W'(-dq) : DX_W'(dq);
                        md_reg    <= dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
                        neg_reg   <= dy[DY_W-1] ^ dq[DX_W-1] ^ dx[DX_W-1];
                        state_reg <= ST_MUL_LO;
                    end
                end
                ST_MUL_LO: begin
                    plo_reg   <= mul_p;
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    phi_reg   <= mul_p[MUL_W-2:0];
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    prod_reg  <= {phi_reg, {MLO_W{1'b0}}} + PROD_W'(plo_reg);
                    state_reg <= ST_PRECHK;
                end
                ST_PRECHK: begin
                    if (prod_reg[PROD_W-1:QUO_W] >= md_reg) begin
                        res_value_reg <= neg_reg ? pwlti_pkg::Y_MIN : pwlti_pkg::Y_MAX;
                        res_clamp_reg <= 1'b1;
                        state_reg     <= ST_DONE;
                    end else begin
                        rem_reg   <= prod_reg[PROD_W-1:QUO_W];
                        nq_reg    <= prod_reg[QUO_W-1:0];
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_ge ? rem_sub[DX_W-1:0] : rem_sh[DX_W-1:0];
                    nq_reg  <= {nq_reg[QUO_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + DCW'(1);
                    if (cnt_reg == DCW'(QUO_W - 1)) begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (sum_s > SUM_W'(pwlti_pkg::Y_MAX)) begin
                        res_value_reg <= pwlti_pkg::Y_MAX;
                        res_clamp_reg <= 1'b1;
                    end else if (sum_s < SUM_W'(pwlti_pkg::Y_MIN)) begin
                        res_value_reg <= pwlti_pkg::Y_MIN;
                        res_clamp_reg <= 1'b1;
                    end else begin
                        res_value_reg <= sum_s[Y_W-1:0];
                        res_clamp_reg <= 1'b0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_value_reg  <= res_value_reg;
                        m_clamp_reg  <= res_clamp_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_clamp_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table_interpolator: a directed table of
// breakpoint loads and lookups, then randomized table settings checked by a predictor.
// Depends on pwlti_pkg and the interpolator RTL only.
module tb;

    localparam int SLOTS        = pwlti_pkg::TABLE_DEPTH_DEF;
    localparam int X_W          = pwlti_pkg::X_W;
    localparam int Y_W          = pwlti_pkg::Y_W;
    localparam int IDX_W        = pwlti_pkg::IDX_W;
    localparam int PIU_W        = pwlti_pkg::PIU_W;
    localparam int S_DATA_W     = pwlti_pkg::S_DATA_W;
    localparam int M_DATA_W     = pwlti_pkg::M_DATA_W;
    localparam int APB_ADDR_W   = pwlti_pkg::APB_ADDR_W;
    localparam int APB_DATA_W   = pwlti_pkg::APB_DATA_W;
    localparam int ITEM_TARGET  = 1700;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam logic signed [X_W-1:0] X_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [X_W-1:0] X_MIN = 32'sh8000_0000;
    localparam logic signed [Y_W-1:0] Y_MAX = pwlti_pkg::Y_MAX;
    localparam logic signed [Y_W-1:0] Y_MIN = pwlti_pkg::Y_MIN;

    typedef struct packed {
        logic                  mode;
        logic [IDX_W-1:0]      index;
        logic signed [X_W-1:0] px;
        logic signed [Y_W-1:0] py;
        logic signed [X_W-1:0] qx;
    } request_t;

    typedef struct packed {
        logic signed [Y_W-1:0] value;
        logic                  clamped;
    } lookup_t;

    typedef enum logic [1:0] {ROW_COUNT, ROW_WRITE, ROW_QUERY} row_kind_t;

    // The x column is the abscissa written or the abscissa queried.
    typedef struct packed {
        row_kind_t             kind;
        logic [PIU_W-1:0]      arg;
        logic signed [X_W-1:0] x;
        logic signed [Y_W-1:0] y;
        logic                  typed;
        logic signed [Y_W-1:0] exp_value;
        logic                  exp_clamped;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [27] = '{
        '{ROW_QUERY, 9'd0,   32'sd0,    48'sd0,     1'b1, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   X_MAX,     48'sd0,     1'b1, 48'sd0,     1'b0},
        '{ROW_COUNT, 9'd1,   32'sd0,    48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd0,   -32'sd100, 48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   -32'sd5,   48'sd0,     1'b1, 48'sd0,     1'b0},
        '{ROW_COUNT, 9'd4,   32'sd0,    48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd1,   32'sd0,    48'sd999,   1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd2,   32'sd100,  48'sd3000,  1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd3,   32'sd200,  -48'sd2000, 1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   -32'sd100, 48'sd0,     1'b1, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   32'sd50,   48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   -32'sd150, 48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   32'sd150,  48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   32'sd201,  48'sd0,     1'b1, -48'sd2000, 1'b0},
        '{ROW_QUERY, 9'd0,   X_MAX,     48'sd0,     1'b1, -48'sd2000, 1'b0},
        '{ROW_QUERY, 9'd0,   X_MIN,     48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd255, X_MAX,     Y_MAX,      1'b0, 48'sd0,     1'b0},
        '{ROW_COUNT, 9'd2,   32'sd0,    48'sd0,     1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd0,   32'sd0,    Y_MAX,      1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd1,   32'sd1,    Y_MIN,      1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   X_MIN,     48'sd0,     1'b1, Y_MAX,      1'b1},
        '{ROW_QUERY, 9'd0,   -32'sd1,   48'sd0,     1'b1, Y_MAX,      1'b1},
        '{ROW_QUERY, 9'd0,   32'sd1,    48'sd0,     1'b1, Y_MIN,      1'b0},
        '{ROW_WRITE, 9'd0,   32'sd5,    48'sd111,   1'b0, 48'sd0,     1'b0},
        '{ROW_WRITE, 9'd1,   32'sd5,    48'sd222,   1'b0, 48'sd0,     1'b0},
        '{ROW_QUERY, 9'd0,   32'sd0,    48'sd0,     1'b1, 48'sd222,   1'b1},
        '{ROW_QUERY, 9'd0,   32'sd5,    48'sd0,     1'b1, 48'sd222,   1'b1}
    };

    localparam int FIXED_COUNTS [7] = '{2, 256, 0, 3, 511, 1, 5};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic signed [X_W-1:0] abscissa_tab [SLOTS];
    logic signed [Y_W-1:0] ordinate_tab [SLOTS];
    logic [PIU_W-1:0]      count_cfg;
    lookup_t               expected_lookups [$];
    int                    error_count;
    int                    items_sent;
    int                    lookups_checked;
    int                    settings_run;
    bit                    no_gaps;

    piecewise_linear_table_interpolator #(
        .TABLE_DEPTH(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic lookup_t interpolate_segment(input int k, input logic signed [X_W-1:0] q);
        lookup_t               r;
        logic signed [X_W-1:0] x0, x1;
        logic signed [Y_W-1:0] y0, y1;
        logic signed [51:0]    dy, dq, dx;
        logic [51:0]           ady, adq, adx;
        logic [103:0]          prod, quo;
        logic signed [53:0]    offset, sum;
        bit                    neg;
        x0 = abscissa_tab[k-1];
        x1 = abscissa_tab[k];
        y0 = ordinate_tab[k-1];
        y1 = ordinate_tab[k];
        if (x1 == x0) begin
            r.value   = y1;
            r.clamped = 1'b1;
            return r;
        end
        dy   = 52'(y1) - 52'(y0);
        dq   = 52'(q) - 52'(x0);
        dx   = 52'(x1) - 52'(x0);
        ady  = dy[51] ? -dy : dy;
        adq  = dq[51] ? -dq : dq;
        adx  = dx[51] ? -dx : dx;
        neg  = dy[51] ^ dq[51] ^ dx[51];
        prod = {52'b0, ady} * {52'b0, adq};
        quo  = prod / {52'b0, adx};
        if (quo >= (104'd1 << 49)) begin
            r.value   = neg ? Y_MIN : Y_MAX;
            r.clamped = 1'b1;
            return r;
        end
        offset = $signed({4'b0, quo[49:0]});
        sum    = neg ? (54'(y0) - offset) : (54'(y0) + offset);
        r.clamped = 1'b0;
        if (sum > 54'(Y_MAX)) begin
            sum       = 54'(Y_MAX);
            r.clamped = 1'b1;
        end
        if (sum < 54'(Y_MIN)) begin
            sum       = 54'(Y_MIN);
            r.clamped = 1'b1;
        end
        r.value = sum[Y_W-1:0];
        return r;
    endfunction

    function automatic lookup_t predict_lookup(input logic signed [X_W-1:0] q);
        lookup_t r;
        int      n;
        int      k;
        bit      found;
        r.value   = '0;
        r.clamped = 1'b0;
        found     = 1'b0;
        n = (int'(count_cfg) > SLOTS) ? SLOTS : int'(count_cfg);
        if (n >= 2) begin
            for (k = 1; k < n && !found; k++) begin
                if (abscissa_tab[k] >= q) begin
                    r     = interpolate_segment(k, q);
                    found = 1'b1;
                end
            end
            if (!found) begin
                r.value = ordinate_tab[n-1];
            end
        end
        return r;
    endfunction

    function automatic request_t random_request(input logic mode);
        request_t    r;
        logic [63:0] bits;
        bits    = {$urandom, $urandom};
        r.mode  = mode;
        r.index = 8'($urandom_range(0, SLOTS - 1));
        r.px    = $urandom;
        r.py    = bits[Y_W-1:0];
        r.qx    = $urandom;
        return r;
    endfunction

    task automatic send_request(input request_t req, input bit typed, input lookup_t typed_result);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {req.qx, req.py, req.px, req.index};
        s_tuser  <= req.mode;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (req.mode == pwlti_pkg::MODE_WRITE) begin
            abscissa_tab[req.index] = req.px;
            ordinate_tab[req.index] = req.py;
        end else begin
            expected_lookups.push_back(typed ? typed_result : predict_lookup(req.qx));
        end
    endtask

    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_count(input logic [PIU_W-1:0] count);
        logic [APB_DATA_W-1:0] rd;
        settle_idle();
        apb_transfer(1'b1, {pwlti_pkg::REG_POINTS_IN_USE, 2'b00}, 32'(count), rd);
        count_cfg = count;
        apb_transfer(1'b0, {pwlti_pkg::REG_POINTS_IN_USE, 2'b00}, '0, rd);
        if (rd !== 32'(count)) begin
            error_count++;
            $error("points_in_use readback mismatch: expected %0d, got %0d", count, rd);
        end
        settings_run++;
    endtask

    task automatic run_phase(input int count);
        int       n, style, body, j, seg;
        bit       zero_first;
        longint   maxstep, x_cur, lo, hi, tmp;
        request_t req;
        program_count(PIU_W'(count));
        n          = (count > SLOTS) ? SLOTS : count;
        style      = $urandom_range(0, 3);
        zero_first = (n >= 2) && ($urandom_range(0, 5) == 0);
        maxstep    = (style == 0) ? 64'd1000 : (64'd4294967295 / ((n > 0) ? n : 1));
        x_cur      = -64'sd2147483648 + ($urandom % (64'd4294967296 - maxstep * n));
        // Load every slot in use so that no lookup reads an unwritten slot.
        for (j = 0; j < n; j++) begin
            req       = random_request(pwlti_pkg::MODE_WRITE);
            req.index = 8'(j);
            if (style != 3) begin
                req.px = 32'(x_cur);
                x_cur  = x_cur + ($urandom % (maxstep + 1));
                if (style != 2) begin
                    req.py = $urandom_range(0, 200000);
                    req.py = req.py - 48'sd100000;
                end
            end
            if (j == 1 && zero_first) begin
                req.px = abscissa_tab[0];
            end
            send_request(req, 1'b0, '0);
        end
        body = (n > 64) ? 12 : int'($urandom_range(40, 90));
        for (j = 0; j < body; j++) begin
            if ($urandom_range(0, 99) < 10) begin
                req = random_request(pwlti_pkg::MODE_WRITE);
                if (n < SLOTS && $urandom_range(0, 1) == 1) begin
                    req.index = 8'($urandom_range(n, SLOTS - 1));
                end
            end else begin
                req = random_request(pwlti_pkg::MODE_QUERY);
                if (n >= 2) begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: begin
                            seg = $urandom_range(1, n - 1);
                            lo  = abscissa_tab[seg-1];
                            hi  = abscissa_tab[seg];
                            if (lo > hi) begin
                                tmp = lo;
                                lo  = hi;
                                hi  = tmp;
                            end
                            req.qx = 32'(lo + ($urandom % (hi - lo + 1)));
                        end
                        3: req.qx = abscissa_tab[$urandom_range(0, n - 1)];
                        4: begin
                            if ($urandom_range(0, 1) == 1) begin
                                req.qx = abscissa_tab[0] - 32'($urandom_range(0, 5000));
                            end else begin
                                req.qx = abscissa_tab[n-1] + 32'($urandom_range(0, 5000));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            send_request(req, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin : result_check
        lookup_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lookups.size() == 0) begin
                error_count++;
                $error("unexpected result: value %0d, clamped %0d", $signed(m_tdata), m_tuser);
            end else begin
                exp_r = expected_lookups.pop_front();
                if (m_tdata !== exp_r.value) begin
                    error_count++;
                    $error("value mismatch: expected %0d, got %0d",
                           $signed(exp_r.value), $signed(m_tdata));
                end
                if (m_tuser !== exp_r.clamped) begin
                    error_count++;
                    $error("clamped mismatch: expected %0d, got %0d", exp_r.clamped, m_tuser);
                end
            end
            lookups_checked++;
        end
    end

    initial begin : result_sink
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && lookups_checked >= HOLD_AFTER) begin
                held     = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin
        #(64'd50_000_000);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        request_t req;
        lookup_t  typed_result;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = pwlti_pkg::MODE_WRITE;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        count_cfg       = '0;
        no_gaps         = 1'b0;
        error_count     = 0;
        items_sent      = 0;
        lookups_checked = 0;
        settings_run    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_COUNT) begin
                program_count(DIRECTED_ROWS[i].arg);
            end else begin
                req.mode  = (DIRECTED_ROWS[i].kind == ROW_QUERY) ? pwlti_pkg::MODE_QUERY
                                                                 : pwlti_pkg::MODE_WRITE;
                req.index = DIRECTED_ROWS[i].arg[IDX_W-1:0];
                req.px    = DIRECTED_ROWS[i].x;
                req.py    = DIRECTED_ROWS[i].y;
                req.qx    = DIRECTED_ROWS[i].x;
                typed_result.value   = DIRECTED_ROWS[i].exp_value;
                typed_result.clamped = DIRECTED_ROWS[i].exp_clamped;
                send_request(req, DIRECTED_ROWS[i].typed, typed_result);
            end
        end

        foreach (FIXED_COUNTS[i]) begin
            no_gaps = (i == 3);
            run_phase(FIXED_COUNTS[i]);
        end
        no_gaps = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1))
                                                  : int'($urandom_range(2, 24)));
        end

        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Sent %0d requests and checked %0d lookups over %0d table settings,",
                 items_sent, lookups_checked, settings_run);
        $display("including empty, single-point, full and oversized point counts.");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
